// ===== hw/rtl/spm_pkg.sv =====
// ============================================================================
// spm_pkg: shared types and constants of the peak-to-peak sound level meter
// Field widths, register indexes, reset values and sequencer states.
// ============================================================================
package spm_pkg;

    // Fixed field widths.
    localparam int LEVEL_W    = 12;
    localparam int DB_W       = 7;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DB_SPAN_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DB_FLOOR            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DB_CEILING          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_CODE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_LIMIT          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_PER_AVERAGE = 3'd7;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] RST_DB_SPAN_LEVEL       = 12'd2000;
    localparam logic [DB_W-1:0]    RST_DB_FLOOR            = 7'd30;
    localparam logic [DB_W-1:0]    RST_DB_CEILING          = 7'd90;
    localparam logic [LEVEL_W-1:0] RST_REJECT_CODE         = 12'd4095;
    localparam logic [DB_W-1:0]    RST_QUIET_LIMIT         = 7'd40;
    localparam logic [DB_W-1:0]    RST_NORMAL_LIMIT        = 7'd60;
    localparam logic [DB_W-1:0]    RST_LOUD_LIMIT          = 7'd80;
    localparam logic [DB_W-1:0]    RST_WINDOWS_PER_AVERAGE = 7'd11;

    // Loudness class codes.
    localparam logic [CLASS_W-1:0] CLASS_QUIET     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_NORMAL    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LOUD      = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_VERY_LOUD = 2'd3;

    // Window-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_DB_START,
        ST_DB_WAIT,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_DONE
    } spm_state_t;

endpackage

// ===== hw/rtl/spm_channels.sv =====
// ============================================================================
// spm_channels: valid/ready channels of the sound level meter
// One interface for the sample words and one for the result words.
// ============================================================================

interface spm_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic                   window_end;

    modport source (output valid, output adc_sample, output window_end, input ready);
    modport sink   (input valid, input adc_sample, input window_end, output ready);
endinterface

interface spm_result_if;
    logic                          valid;
    logic                          ready;
    logic [spm_pkg::LEVEL_W-1:0]   peak_to_peak;
    logic [spm_pkg::DB_W-1:0]      level_db;
    logic [spm_pkg::CLASS_W-1:0]   loudness_class;
    logic [spm_pkg::LEVEL_W-1:0]   max_level;
    logic [spm_pkg::LEVEL_W-1:0]   avg_level;
    logic                          avg_updated;

    modport source (output valid, output peak_to_peak, output level_db,
                    output loudness_class, output max_level, output avg_level,
                    output avg_updated, input ready);
    modport sink   (input valid, input peak_to_peak, input level_db,
                    input loudness_class, input max_level, input avg_level,
                    input avg_updated, output ready);
endinterface

// ===== hw/rtl/spm_divider.sv =====
// ============================================================================
// spm_divider: shared restoring divider
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ============================================================================
module spm_divider #(
    parameter int DVD_W = 19,
    parameter int DIV_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DIV_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    shifted;
    logic              fits;
    logic [DIV_W:0]    diff;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        fits    = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    // Control: step counter, busy flag and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/sound_peak_to_peak_meter.sv =====
// ============================================================================
// sound_peak_to_peak_meter: windowed peak-to-peak sound level meter
//
//   Channel    Dir   Word contents
//   samples    in    adc_sample, window_end
//   results    out   peak_to_peak, level_db, loudness_class, max_level,
//                    avg_level, avg_updated
//   cfg_*      in    write enable, register index, write data (no handshake)
//
// Samples without window_end are taken while the sequencer is idle. A window
// end holds off input while the sequencer forms the range product, then runs
// the dB division and, if it closes an averaging block, the average division;
// the shared serial divider gives one quotient bit a cycle for each. Reset
// sets configuration, measurement state, sequencer and output valid at once;
// no clearing pass. A waiting result does not hold off further samples; only
// the next window end waits in ST_DONE until the output register is free.
// ============================================================================
module sound_peak_to_peak_meter #(
    parameter int SAMPLE_BITS     = 12,
    parameter int MAX_AVG_WINDOWS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    spm_sample_if.sink                       samples,
    spm_result_if.source                     results,
    input  logic                             cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LEVEL_W = spm_pkg::LEVEL_W;
    localparam int DB_W    = spm_pkg::DB_W;
    localparam int CMP_W   = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int CNT_W   = $clog2(MAX_AVG_WINDOWS + 1);
    localparam int SUM_W   = LEVEL_W + $clog2(MAX_AVG_WINDOWS);
    localparam int PROD_W  = LEVEL_W + DB_W;
    localparam int DVD_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int LEN_W   = (CNT_W > DB_W) ? CNT_W : DB_W;

    // Configuration registers.
    logic [LEVEL_W-1:0] span_reg;
    logic [DB_W-1:0]    floor_reg;
    logic [DB_W-1:0]    ceiling_reg;
    logic [LEVEL_W-1:0] reject_reg;
    logic [DB_W-1:0]    quiet_reg;
    logic [DB_W-1:0]    normal_reg;
    logic [DB_W-1:0]    loud_reg;
    logic [DB_W-1:0]    wpa_reg;

    // Measurement state.
    logic [SAMPLE_BITS-1:0] high_reg;
    logic [SAMPLE_BITS-1:0] low_reg;
    logic [LEVEL_W-1:0]     peak_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [LEVEL_W-1:0]     avg_reg;

    // Window-end working registers.
    logic [LEVEL_W-1:0] level_reg;
    logic               avg_due_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DB_W-1:0]    db_reg;

    // Output register.
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_p2p_reg;
    logic [DB_W-1:0]    out_db_reg;
    logic [spm_pkg::CLASS_W-1:0] out_class_reg;
    logic [LEVEL_W-1:0] out_max_reg;
    logic [LEVEL_W-1:0] out_avg_reg;
    logic               out_upd_reg;

    spm_pkg::spm_state_t state_reg;
    spm_pkg::spm_state_t state_next;

    logic               in_ready;
    logic               div_start;
    logic               div_sel_avg;
    logic               out_load;
    logic               accept;

    logic               smp_ok;
    logic [SAMPLE_BITS-1:0] high_next;
    logic [SAMPLE_BITS-1:0] low_next;
    logic [CMP_W-1:0]   lvl_diff;
    logic [LEVEL_W-1:0] level_next;
    logic [CNT_W-1:0]   count_next;
    logic [LEN_W-1:0]   avg_len;
    logic               diff_neg;
    logic [DB_W-1:0]    diff_mag;
    logic [LEVEL_W-1:0] span_eff;
    logic [DVD_W-1:0]   div_dividend;
    logic [LEVEL_W-1:0] div_divisor;
    logic               div_done;
    logic [DVD_W-1:0]   div_quotient;
    logic [DB_W-1:0]    db_next;
    logic [spm_pkg::CLASS_W-1:0] class_next;

    assign accept = samples.valid && in_ready;

    // Sample qualification and window extremes including the current sample.
    always_comb
    begin
        smp_ok     = (CMP_W'(samples.adc_sample) < CMP_W'(reject_reg));
        high_next  = (smp_ok && (samples.adc_sample > high_reg)) ? samples.adc_sample
                                                                 : high_reg;
        low_next   = (smp_ok && (samples.adc_sample < low_reg)) ? samples.adc_sample
                                                                : low_reg;
        lvl_diff   = CMP_W'(high_next) - CMP_W'(low_next);
        level_next = (high_next >= low_next) ? lvl_diff[LEVEL_W-1:0] : '0;
        count_next = count_reg + 1'b1;
    end

    // Averaging block length: zero counts as one, capped at the maximum.
    always_comb
    begin
        if (wpa_reg == '0)
        begin
            avg_len = LEN_W'(1);
        end
        else if (LEN_W'(wpa_reg) > LEN_W'(MAX_AVG_WINDOWS))
        begin
            avg_len = LEN_W'(MAX_AVG_WINDOWS);
        end
        else
        begin
            avg_len = LEN_W'(wpa_reg);
        end
    end

    // dB scale terms: magnitude and sign of the range, and a nonzero span.
    always_comb
    begin
        diff_neg = (ceiling_reg < floor_reg);
        diff_mag = diff_neg ? (floor_reg - ceiling_reg) : (ceiling_reg - floor_reg);
        span_eff = (span_reg == '0) ? LEVEL_W'(1) : span_reg;
    end

    // Clamp of the scaled level. With a falling range any nonzero quotient
    // lands below the floor, and a zero quotient lands above the ceiling.
    always_comb
    begin
        if (diff_neg)
        begin
            db_next = (div_quotient == '0) ? ceiling_reg : floor_reg;
        end
        else if (div_quotient > DVD_W'(diff_mag))
        begin
            db_next = ceiling_reg;
        end
        else
        begin
            db_next = floor_reg + div_quotient[DB_W-1:0];
        end
    end

    // Loudness class, tested in order quiet, normal, loud.
    always_comb
    begin
        if (db_reg < quiet_reg)
        begin
            class_next = spm_pkg::CLASS_QUIET;
        end
        else if (db_reg < normal_reg)
        begin
            class_next = spm_pkg::CLASS_NORMAL;
        end
        else if (db_reg < loud_reg)
        begin
            class_next = spm_pkg::CLASS_LOUD;
        end
        else
        begin
            class_next = spm_pkg::CLASS_VERY_LOUD;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                if (accept && samples.window_end)
                begin
                    state_next = spm_pkg::ST_MULT;
                end
            end
            spm_pkg::ST_MULT:      state_next = spm_pkg::ST_DB_START;
            spm_pkg::ST_DB_START:  state_next = spm_pkg::ST_DB_WAIT;
            spm_pkg::ST_DB_WAIT:
            begin
                if (div_done)
                begin
                    state_next = avg_due_reg ? spm_pkg::ST_AVG_START : spm_pkg::ST_DONE;
                end
            end
            spm_pkg::ST_AVG_START: state_next = spm_pkg::ST_AVG_WAIT;
            spm_pkg::ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = spm_pkg::ST_DONE;
                end
            end
            spm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = spm_pkg::ST_IDLE;
                end
            end
            default:               state_next = spm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        div_sel_avg = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            spm_pkg::ST_IDLE:      in_ready = 1'b1;
            spm_pkg::ST_DB_START:  div_start = 1'b1;
            spm_pkg::ST_AVG_START:
            begin
                div_start   = 1'b1;
                div_sel_avg = 1'b1;
            end
            spm_pkg::ST_DONE:      out_load = !out_valid_reg || results.ready;
            default:               in_ready = 1'b0;
        endcase
    end

    // Divider operand selection.
    always_comb
    begin
        div_dividend = div_sel_avg ? DVD_W'(sum_reg) : DVD_W'(prod_reg);
        div_divisor  = div_sel_avg ? LEVEL_W'(count_reg) : span_eff;
    end

    spm_divider #(
        .DVD_W (DVD_W),
        .DIV_W (LEVEL_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg    <= spm_pkg::RST_DB_SPAN_LEVEL;
            floor_reg   <= spm_pkg::RST_DB_FLOOR;
            ceiling_reg <= spm_pkg::RST_DB_CEILING;
            reject_reg  <= spm_pkg::RST_REJECT_CODE;
            quiet_reg   <= spm_pkg::RST_QUIET_LIMIT;
            normal_reg  <= spm_pkg::RST_NORMAL_LIMIT;
            loud_reg    <= spm_pkg::RST_LOUD_LIMIT;
            wpa_reg     <= spm_pkg::RST_WINDOWS_PER_AVERAGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spm_pkg::REG_DB_SPAN_LEVEL:       span_reg    <= cfg_data[LEVEL_W-1:0];
                spm_pkg::REG_DB_FLOOR:            floor_reg   <= cfg_data[DB_W-1:0];
                spm_pkg::REG_DB_CEILING:          ceiling_reg <= cfg_data[DB_W-1:0];
                spm_pkg::REG_REJECT_CODE:         reject_reg  <= cfg_data[LEVEL_W-1:0];
                spm_pkg::REG_QUIET_LIMIT:         quiet_reg   <= cfg_data[DB_W-1:0];
                spm_pkg::REG_NORMAL_LIMIT:        normal_reg  <= cfg_data[DB_W-1:0];
                spm_pkg::REG_LOUD_LIMIT:          loud_reg    <= cfg_data[DB_W-1:0];
                spm_pkg::REG_WINDOWS_PER_AVERAGE: wpa_reg     <= cfg_data[DB_W-1:0];
                default:                          span_reg    <= span_reg;
            endcase
        end
    end

    // Window tracking, peak hold and block accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg    <= '0;
            low_reg     <= '1;
            peak_reg    <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            avg_reg     <= '0;
            avg_due_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (samples.window_end)
                begin
                    high_reg    <= '0;
                    low_reg     <= '1;
                    if (level_next > peak_reg)
                    begin
                        peak_reg <= level_next;
                    end
                    sum_reg     <= sum_reg + SUM_W'(level_next);
                    count_reg   <= count_next;
                    avg_due_reg <= (LEN_W'(count_next) >= avg_len);
                end
                else
                begin
                    high_reg <= high_next;
                    low_reg  <= low_next;
                end
            end
            // The divider has latched sum and count; the block restarts.
            if (div_start && div_sel_avg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if ((state_reg == spm_pkg::ST_AVG_WAIT) && div_done)
            begin
                avg_reg <= div_quotient[LEVEL_W-1:0];
            end
        end
    end

    // Window-end datapath: level capture, range product and scaled dB.
    always_ff @(posedge clk)
    begin
        if (accept && samples.window_end)
        begin
            level_reg <= level_next;
        end
        if (state_reg == spm_pkg::ST_MULT)
        begin
            prod_reg <= PROD_W'(level_reg) * PROD_W'(diff_mag);
        end
        if ((state_reg == spm_pkg::ST_DB_WAIT) && div_done)
        begin
            db_reg <= db_next;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: result word.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_p2p_reg   <= level_reg;
            out_db_reg    <= db_reg;
            out_class_reg <= class_next;
            out_max_reg   <= peak_reg;
            out_avg_reg   <= avg_reg;
            out_upd_reg   <= avg_due_reg;
        end
    end

    assign samples.ready          = in_ready;
    assign results.valid          = out_valid_reg;
    assign results.peak_to_peak   = out_p2p_reg;
    assign results.level_db       = out_db_reg;
    assign results.loudness_class = out_class_reg;
    assign results.max_level      = out_max_reg;
    assign results.avg_level      = out_avg_reg;
    assign results.avg_updated    = out_upd_reg;

endmodule
